// ===== hdl/t9wpm_pkg.sv =====
package t9wpm_pkg;

    // Key code as held in the pattern register and produced by the character map
    typedef logic [3:0] key_t;

    // Configuration register indexes
    typedef enum logic [0:0] {
        CFG_PATTERN_KEYS   = 1'b0,
        CFG_PATTERN_LENGTH = 1'b1
    } cfg_addr_t;

    localparam int unsigned KEYS_W    = 48;
    localparam int unsigned LENGTH_W  = 4;
    localparam int unsigned KEY_W     = 4;
    localparam int unsigned KEY_SLOTS = KEYS_W / KEY_W;

    // Key codes that are not plain digits
    localparam key_t KEY_STAR = 4'd10;

    // Characters with a meaning of their own
    localparam logic [15:0] CHAR_PLUS  = 16'h002B;
    localparam logic [15:0] CHAR_SPACE = 16'h0020;

    // Cyrillic folding onto the upper half of the byte table
    localparam logic [15:0] CYR_FIRST   = 16'h0410;
    localparam logic [15:0] CYR_END     = 16'h0450;
    localparam logic [15:0] CYR_SHIFT   = 16'h0350;
    localparam logic [15:0] CYR_IO_UP   = 16'h0401;
    localparam logic [7:0]  CYR_IO_UP_B = 8'hA8;
    localparam logic [15:0] CYR_IO_LO   = 16'h0451;
    localparam logic [7:0]  CYR_IO_LO_B = 8'hB8;

    // Phone-key table over the folded byte
    function automatic key_t byte_to_key(input logic [7:0] b);
        key_t k;
        unique case (b) inside
            8'h21, 8'h22, 8'h23, 8'h27, 8'h2B, 8'h2C, 8'h2D, 8'h2E,
            8'h3A, 8'h3B, 8'h3F, 8'h40, 8'h5F:
                k = 4'd0;
            8'h25, 8'h26, 8'h28, 8'h29, 8'h2A, 8'h2F, 8'h3C, 8'h3D,
            8'h3E, 8'h5C, 8'h7E:
                k = KEY_STAR;
            [8'h30:8'h39]:
                k = b[3:0];
            [8'h41:8'h43], [8'h61:8'h63], [8'hC0:8'hC3], [8'hE0:8'hE3]:
                k = 4'd2;
            [8'h44:8'h46], [8'h64:8'h66], [8'hC4:8'hC7], [8'hE4:8'hE7],
            8'hA8, 8'hB8:
                k = 4'd3;
            [8'h47:8'h49], [8'h67:8'h69], [8'hC8:8'hCB], [8'hE8:8'hEB]:
                k = 4'd4;
            [8'h4A:8'h4C], [8'h6A:8'h6C], [8'hCC:8'hCE], [8'hEC:8'hEE]:
                k = 4'd5;
            [8'h4D:8'h4F], [8'h6D:8'h6F], [8'hCF:8'hD1], [8'hEF:8'hF1]:
                k = 4'd6;
            [8'h50:8'h53], [8'h70:8'h73], [8'hD2:8'hD5], [8'hF2:8'hF5]:
                k = 4'd7;
            [8'h54:8'h56], [8'h74:8'h76], [8'hD6:8'hDA], [8'hF6:8'hFA]:
                k = 4'd8;
            [8'h57:8'h5A], [8'h77:8'h7A], [8'hDB:8'hDF], [8'hFB:8'hFF]:
                k = 4'd9;
            default:
                k = 4'd1;
        endcase
        return k;
    endfunction

endpackage

// ===== hdl/t9wpm_char_key.sv =====
module t9wpm_char_key
    import t9wpm_pkg::*;
(
    input  logic [15:0] char_code,
    output key_t        key
);

    logic [7:0] folded;

    // Fold Cyrillic onto the upper byte range, keep the low byte otherwise
    always_comb begin
        if (char_code >= CYR_FIRST && char_code < CYR_END) begin
            folded = char_code[7:0] - CYR_SHIFT[7:0];
        end else if (char_code == CYR_IO_UP) begin
            folded = CYR_IO_UP_B;
        end else if (char_code == CYR_IO_LO) begin
            folded = CYR_IO_LO_B;
        end else begin
            folded = char_code[7:0];
        end
    end

    // Look up the phone key
    assign key = byte_to_key(folded);

endmodule

// ===== hdl/t9_word_prefix_matcher.sv =====
// Keypad prefix matcher: characters of one string are transferred one per cycle on the s_
// channel, the final one flagged by s_last, and one m_matched result is transferred per string.
// An item passes an input register, then the key lookup and pattern compare sit between that
// register and the per-string state and result registers, so the block takes one character
// every cycle unless stalled, and the result is registered as the last character leaves the
// input register. The only stall comes from the result register: a final character waits in
// the input register while an earlier result has not been taken. pattern_keys (index 0) and
// pattern_length (index 1) are written through cfg_wr_en/cfg_addr/cfg_wr_data, by the user only
// while no string is in flight, unchecked; a length over PATTERN_MAX is treated as PATTERN_MAX.
module t9_word_prefix_matcher
    import t9wpm_pkg::*;
#(
    parameter int unsigned PATTERN_MAX = 12
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                cfg_wr_en,
    input  logic [0:0]          cfg_addr,
    input  logic [KEYS_W-1:0]   cfg_wr_data,
    input  logic                s_valid,
    output logic                s_ready,
    input  logic [15:0]         s_char_code,
    input  logic                s_char_valid,
    input  logic                s_last,
    output logic                m_valid,
    input  logic                m_ready,
    output logic                m_matched
);

    localparam int unsigned POS_BITS = $clog2(PATTERN_MAX + 2);
    localparam int unsigned CNT_W    = (POS_BITS > LENGTH_W) ? POS_BITS : LENGTH_W;
    localparam int unsigned SLOT_W   = $clog2(KEY_SLOTS);

    // Configuration
    logic [KEYS_W-1:0]   pattern_keys_reg;
    logic [LENGTH_W-1:0] pattern_length_reg;

    // Input stage
    logic                in_valid_reg;
    logic [15:0]         in_char_reg;
    logic                in_char_valid_reg;
    logic                in_last_reg;

    // Per-string state
    logic [CNT_W-1:0]    word_position_reg, word_position_next;
    logic                at_start_reg, at_start_next;
    logic                match_found_reg, match_found_next;

    // Result stage
    logic                m_valid_reg;
    logic                m_matched_reg;

    logic                out_free;
    logic                in_advance;
    key_t                char_key;
    key_t                want_key;
    key_t                slot_keys [KEY_SLOTS];
    logic [CNT_W-1:0]    eff_length;
    logic [CNT_W-1:0]    key_index;
    logic                plen_zero;

    // Write configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pattern_keys_reg   <= '0;
            pattern_length_reg <= '0;
        end else if (cfg_wr_en) begin
            unique case (cfg_addr_t'(cfg_addr))
                CFG_PATTERN_KEYS:   pattern_keys_reg   <= cfg_wr_data;
                CFG_PATTERN_LENGTH: pattern_length_reg <= cfg_wr_data[LENGTH_W-1:0];
                default:            pattern_keys_reg   <= pattern_keys_reg;
            endcase
        end
    end

    // Handshake between the stages
    assign out_free   = !m_valid_reg || m_ready;
    assign in_advance = in_valid_reg && (!in_last_reg || out_free);
    assign s_ready    = !in_valid_reg || in_advance;

    // Input register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_ready) begin
            in_valid_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_ready && s_valid) begin
            in_char_reg       <= s_char_code;
            in_char_valid_reg <= s_char_valid;
            in_last_reg       <= s_last;
        end
    end

    t9wpm_char_key u_char_key (
        .char_code (in_char_reg),
        .key       (char_key)
    );

    // Saturate the pattern length
    always_comb begin
        eff_length = CNT_W'(pattern_length_reg);
        if (eff_length > CNT_W'(PATTERN_MAX)) begin
            eff_length = CNT_W'(PATTERN_MAX);
        end
    end
    assign plen_zero = (eff_length == '0);

    // Pick the expected key; slots past the register read as zero
    always_comb begin
        for (int i = 0; i < KEY_SLOTS; i++) begin
            slot_keys[i] = pattern_keys_reg[i*KEY_W +: KEY_W];
        end
    end
    assign key_index = word_position_reg - CNT_W'(1);
    assign want_key  = (key_index < CNT_W'(KEY_SLOTS)) ? slot_keys[key_index[SLOT_W-1:0]]
                                                       : key_t'(0);

    // Advance the word match
    always_comb begin
        word_position_next = word_position_reg;
        at_start_next      = at_start_reg;
        match_found_next   = match_found_reg;
        if (in_char_valid_reg && !match_found_reg && !plen_zero) begin
            at_start_next = 1'b0;
            if (at_start_reg && in_char_reg == CHAR_PLUS) begin
                word_position_next = word_position_reg;
            end else if (word_position_reg == '0) begin
                if (in_char_reg == CHAR_SPACE) begin
                    word_position_next = CNT_W'(1);
                end
            end else if (char_key == want_key) begin
                word_position_next = word_position_reg + CNT_W'(1);
                if (word_position_next > eff_length) begin
                    match_found_next = 1'b1;
                end
            end else begin
                word_position_next = '0;
            end
        end else if (in_char_valid_reg) begin
            at_start_next = 1'b0;
        end
    end

    // Hold per-string state, clear it once the string ends
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            word_position_reg <= CNT_W'(1);
            at_start_reg      <= 1'b1;
            match_found_reg   <= 1'b0;
        end else if (in_advance) begin
            if (in_last_reg) begin
                word_position_reg <= CNT_W'(1);
                at_start_reg      <= 1'b1;
                match_found_reg   <= 1'b0;
            end else begin
                word_position_reg <= word_position_next;
                at_start_reg      <= at_start_next;
                match_found_reg   <= match_found_next;
            end
        end
    end

    // Result register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (in_advance && in_last_reg) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_advance && in_last_reg) begin
            m_matched_reg <= plen_zero || match_found_next;
        end
    end

    assign m_valid   = m_valid_reg;
    assign m_matched = m_matched_reg;

    // Position never runs past one beyond the longest pattern
    a_position_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        word_position_reg <= CNT_W'(PATTERN_MAX + 1))
        else $error("word position out of range");

    // A match needs at least one processed character
    a_match_after_start: assert property (@(posedge aclk) disable iff (!aresetn)
        match_found_reg |-> !at_start_reg)
        else $error("match flagged at string start");

    // The end of a string restores the string state and sets the result valid
    a_clear_on_last: assert property (@(posedge aclk) disable iff (!aresetn)
        (in_advance && in_last_reg) |=>
            (word_position_reg == CNT_W'(1) && at_start_reg && !match_found_reg && m_valid_reg))
        else $error("string state not cleared after result");

    // A held input item is not lost
    a_input_held: assert property (@(posedge aclk) disable iff (!aresetn)
        (in_valid_reg && !in_advance) |=> (in_valid_reg && $stable(in_char_reg)))
        else $error("stalled input item dropped");

endmodule

// ===== tb/t9wpm_keypad_pkg.sv =====
package t9wpm_keypad_pkg;

    import t9wpm_pkg::*;

    // Fold a UCS-2 character onto one byte and look it up in the phone-key table.
    // Cyrillic A..ya lands on 0xC0..0xFF, and the two forms of yo land on 0xA8 and 0xB8.
    function automatic key_t keypad_key(input logic [15:0] code);
        logic [15:0]  folded;
        logic [255:0] row;
        logic [7:0]   ch;
        int unsigned  col;
        folded = code;
        if (code >= CYR_FIRST && code < CYR_END) begin
            folded = code - CYR_SHIFT;
        end else if (code == CYR_IO_UP) begin
            folded = {8'h00, CYR_IO_UP_B};
        end else if (code == CYR_IO_LO) begin
            folded = {8'h00, CYR_IO_LO_B};
        end
        // one row of 32 keys per block of 32 byte values, first character leftmost
        case (folded[7:5])
            3'd0: row = "11111111111111111111111111111111";
            3'd1: row = "10001**0***0000*012345678900***0";
            3'd2: row = "0222333444555666777788899991*110";
            3'd3: row = "122233344455566677778889999111*1";
            3'd4: row = "11111111111111111111111111111111";
            3'd5: row = "11111111311111111111111131111111";
            default: row = "22223333444455566677778888899999";
        endcase
        col = folded[4:0];
        ch = row[(31 - col) * 8 +: 8];
        if (ch == 8'h2A) begin
            return KEY_STAR;
        end
        return key_t'(ch - 8'h30);
    endfunction

endpackage

// ===== tb/t9wpm_match_checker.sv =====
module t9wpm_match_checker
    import t9wpm_pkg::*;
    import t9wpm_keypad_pkg::*;
#(
    parameter int unsigned PATTERN_MAX = 12
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              cfg_wr_en,
    input  logic [0:0]        cfg_addr,
    input  logic [KEYS_W-1:0] cfg_wr_data,
    input  logic              s_valid,
    input  logic              s_ready,
    input  logic [15:0]       s_char_code,
    input  logic              s_char_valid,
    input  logic              s_last,
    input  logic              m_valid,
    input  logic              m_ready,
    input  logic              m_matched,
    output int                pending,
    output int                errors
);
    timeunit 1ns;
    timeprecision 1ps;

    // shadow of the pattern registers
    logic [KEYS_W-1:0]   keys_shadow;
    logic [LENGTH_W-1:0] length_shadow;

    // search state of the current string
    int unsigned next_key;      // 1-based pattern position, 0 while skipping to a space
    bit          first_char;
    bit          pattern_done;

    // match flags owed to the result channel, oldest first
    bit matched_due[$];

    initial begin
        pending = 0;
        errors  = 0;
    end

    function automatic void restart_string();
        next_key     = 1;
        first_char   = 1'b1;
        pattern_done = 1'b0;
    endfunction

    // Advance the prefix search by one accepted character transfer
    function automatic void search_char(input logic [15:0] code, input logic present,
                                        input logic closes);
        int unsigned plen;
        key_t        wanted;
        plen = (length_shadow > PATTERN_MAX) ? PATTERN_MAX : length_shadow;
        if (present && !pattern_done && plen != 0) begin
            if (first_char && code == CHAR_PLUS) begin
                first_char = 1'b0;
            end else begin
                first_char = 1'b0;
                if (next_key == 0) begin
                    if (code == CHAR_SPACE) begin
                        next_key = 1;
                    end
                end else begin
                    // positions past the register read as key zero
                    wanted = (next_key - 1 < KEY_SLOTS) ? keys_shadow[(next_key - 1) * KEY_W +: KEY_W]
                                                        : key_t'(0);
                    if (keypad_key(code) == wanted) begin
                        next_key++;
                        if (next_key > plen) begin
                            pattern_done = 1'b1;
                        end
                    end else begin
                        next_key = 0;
                    end
                end
            end
        end else if (present) begin
            first_char = 1'b0;
        end
        if (closes) begin
            matched_due.push_back(plen == 0 || pattern_done);
            restart_string();
        end
    endfunction

    // Track configuration, predict on input transfers, compare on result transfers
    always @(posedge aclk) begin
        bit want;
        if (!aresetn) begin
            keys_shadow   = '0;
            length_shadow = '0;
            restart_string();
            matched_due.delete();
        end else begin
            if (cfg_wr_en) begin
                if (cfg_addr == CFG_PATTERN_KEYS) begin
                    keys_shadow = cfg_wr_data;
                end else begin
                    length_shadow = cfg_wr_data[LENGTH_W-1:0];
                end
            end
            if (s_valid && s_ready) begin
                search_char(s_char_code, s_char_valid, s_last);
            end
            if (m_valid && m_ready) begin
                if (matched_due.size() == 0) begin
                    $error("m_matched: expected no transfer, got %0b", m_matched);
                    errors++;
                end else begin
                    want = matched_due.pop_front();
                    if (m_matched !== want) begin
                        $error("m_matched: expected %0b, got %0b", want, m_matched);
                        errors++;
                    end
                end
            end
        end
        pending = matched_due.size();
    end

endmodule

// ===== tb/testbench.sv =====
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    import t9wpm_pkg::*;
    import t9wpm_keypad_pkg::*;

    localparam int unsigned PATTERN_MAX = 12;
    localparam int          HOLD_CYCLES = 300;
    localparam int          QUIET_LIMIT = 3000;
    localparam int          PHASE_ITEMS = 60;

    logic              aclk;
    logic              aresetn      = 1'b0;
    logic              cfg_wr_en    = 1'b0;
    logic [0:0]        cfg_addr     = CFG_PATTERN_KEYS;
    logic [KEYS_W-1:0] cfg_wr_data  = '0;
    logic              s_valid      = 1'b0;
    logic              s_ready;
    logic [15:0]       s_char_code  = '0;
    logic              s_char_valid = 1'b0;
    logic              s_last       = 1'b0;
    logic              m_valid;
    logic              m_ready      = 1'b0;
    logic              m_matched;

    int pending;
    int errors;

    int          send_idle_pct = 7;
    int          recv_idle_pct = 71;
    bit          hold_req      = 1'b0;
    int          items_sent    = 0;
    logic [47:0] pat_keys      = '0;
    int          pat_eff       = 0;

    t9_word_prefix_matcher #(
        .PATTERN_MAX (PATTERN_MAX)
    ) i_dut (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .cfg_wr_en    (cfg_wr_en),
        .cfg_addr     (cfg_addr),
        .cfg_wr_data  (cfg_wr_data),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_char_code  (s_char_code),
        .s_char_valid (s_char_valid),
        .s_last       (s_last),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_matched    (m_matched)
    );

    t9wpm_match_checker #(
        .PATTERN_MAX (PATTERN_MAX)
    ) i_checker (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .cfg_wr_en    (cfg_wr_en),
        .cfg_addr     (cfg_addr),
        .cfg_wr_data  (cfg_wr_data),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_char_code  (s_char_code),
        .s_char_valid (s_char_valid),
        .s_last       (s_last),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_matched    (m_matched),
        .pending      (pending),
        .errors       (errors)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    // Result side: random back-pressure, or a long hold when asked for
    initial begin
        forever begin
            @(negedge aclk);
            if (hold_req) begin
                m_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(negedge aclk);
                hold_req <= 1'b0;
            end
            m_ready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    // Abort when no transfer happens on either channel for too long
    initial begin
        int quiet;
        quiet = 0;
        while (quiet < QUIET_LIMIT) begin
            @(posedge aclk);
            if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready)) begin
                quiet = 0;
            end else begin
                quiet++;
            end
        end
        $display("t9_word_prefix_matcher verification failed");
        $finish;
    end

    // Mixed character source: ASCII, Cyrillic, high bytes and anything at all
    function automatic logic [15:0] any_char();
        int pick;
        pick = $urandom_range(9);
        if (pick < 4) begin
            return 16'($urandom_range(16'h7E, 16'h20));
        end else if (pick < 6) begin
            return 16'($urandom_range(16'h45F, 16'h400));
        end else if (pick < 7) begin
            return 16'($urandom_range(16'hFF, 16'h80));
        end
        return 16'($urandom_range(16'hFFFF));
    endfunction

    // Draw until the character lands on the wanted key, at most 400 draws; hash and above have none
    function automatic logic [15:0] char_for_key(input key_t k);
        logic [15:0] c;
        c = any_char();
        if (k <= KEY_STAR) begin
            for (int n = 0; n < 400 && keypad_key(c) != k; n++) begin
                c = any_char();
            end
        end
        return c;
    endfunction

    // One character transfer, with random idle cycles in front of it
    task automatic put_item(input logic [15:0] code, input logic present, input logic closes);
        while ($urandom_range(99) < send_idle_pct) begin
            s_valid <= 1'b0;
            @(negedge aclk);
        end
        s_valid      <= 1'b1;
        s_char_code  <= code;
        s_char_valid <= present;
        s_last       <= closes;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        @(negedge aclk);
        items_sent++;
    endtask

    // Drop valid and wait for every owed result, then let the pipeline drain
    task automatic settle(input int drain);
        s_valid <= 1'b0;
        while (pending != 0) @(negedge aclk);
        repeat (drain) @(negedge aclk);
    endtask

    task automatic set_pattern(input logic [47:0] keys, input logic [3:0] len);
        settle(4);
        cfg_wr_en   <= 1'b1;
        cfg_addr    <= CFG_PATTERN_KEYS;
        cfg_wr_data <= keys;
        @(negedge aclk);
        cfg_addr    <= CFG_PATTERN_LENGTH;
        cfg_wr_data <= KEYS_W'(len);
        @(negedge aclk);
        cfg_wr_en   <= 1'b0;
        pat_keys = keys;
        pat_eff  = (len > PATTERN_MAX) ? PATTERN_MAX : len;
    endtask

    // Short patterns mostly, so that matches are common; extremes now and then
    task automatic random_pattern();
        logic [47:0] keys;
        logic [3:0]  len;
        int          pick;
        for (int i = 0; i < KEY_SLOTS; i++) begin
            keys[i * KEY_W +: KEY_W] = ($urandom_range(9) != 0) ? 4'($urandom_range(10))
                                                               : 4'($urandom_range(15, 11));
        end
        pick = $urandom_range(19);
        if (pick == 0) begin
            keys = '0;
        end else if (pick == 1) begin
            keys = '1;
        end
        pick = $urandom_range(9);
        if (pick == 0) begin
            len = 4'd0;
        end else if (pick == 1) begin
            len = 4'd12;
        end else if (pick == 2) begin
            len = 4'($urandom_range(15, 13));
        end else begin
            len = 4'($urandom_range(4, 1));
        end
        set_pattern(keys, len);
    endtask

    // One string: mostly words built on the pattern, some noise and empty strings
    task automatic send_text();
        logic [15:0] codes[$];
        bit          present[$];
        int          shape;
        int          words;
        int          kind;
        int          cut;
        shape = $urandom_range(99);
        if (shape < 5) begin
            codes.push_back(16'($urandom_range(16'hFFFF)));
            present.push_back(1'b0);
        end else if (shape < 15) begin
            if ($urandom_range(1) == 1) begin
                codes.push_back(CHAR_PLUS);
                present.push_back(1'b1);
            end
            repeat ($urandom_range(8, 1)) begin
                codes.push_back(any_char());
                present.push_back($urandom_range(9) != 0);
            end
        end else begin
            if ($urandom_range(99) < 30) begin
                codes.push_back(CHAR_PLUS);
                present.push_back(1'b1);
            end
            words = $urandom_range(3, 1);
            for (int w = 0; w < words; w++) begin
                if (w != 0) begin
                    repeat ($urandom_range(2, 1)) begin
                        codes.push_back(CHAR_SPACE);
                        present.push_back(1'b1);
                    end
                end
                // whole pattern, a broken prefix, or a plain word
                kind = $urandom_range(3);
                if (kind < 2) begin
                    cut = pat_eff;
                end else if (kind == 2) begin
                    cut = (pat_eff == 0) ? 0 : $urandom_range(pat_eff - 1);
                end else begin
                    cut = 0;
                end
                for (int i = 0; i < cut; i++) begin
                    codes.push_back(char_for_key(pat_keys[i * KEY_W +: KEY_W]));
                    present.push_back(1'b1);
                end
                repeat ($urandom_range(4, (kind == 2 || kind == 3) ? 1 : 0)) begin
                    codes.push_back(any_char());
                    present.push_back(1'b1);
                end
            end
        end
        // close some strings on an empty item
        if (shape >= 5 && $urandom_range(9) == 0) begin
            codes.push_back(16'($urandom_range(16'hFFFF)));
            present.push_back(1'b0);
        end
        foreach (codes[i]) begin
            if ($urandom_range(19) == 0) begin
                put_item(any_char(), 1'b0, 1'b0);
            end
            put_item(codes[i], present[i], i == codes.size() - 1);
        end
    endtask

    initial begin
        int target;
        repeat (12) @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // empty pattern: every string matches, an empty one too
        put_item(16'h0000, 1'b0, 1'b1);
        put_item(16'hFFFF, 1'b1, 1'b1);

        // pattern 2-3-3-9
        set_pattern(48'h9332, 4'd4);
        put_item(16'hFFFF, 1'b0, 1'b1);
        // leading plus skipped, Cyrillic A, both yo forms, ya; the trailing q is ignored
        put_item(CHAR_PLUS, 1'b1, 1'b0);
        put_item(16'h0410, 1'b1, 1'b0);
        put_item(16'h0401, 1'b1, 1'b0);
        put_item(16'h0451, 1'b1, 1'b0);
        put_item(16'h044F, 1'b1, 1'b0);
        put_item(16'h0071, 1'b1, 1'b1);
        // x misses, an empty item mid-string, then "adew" after a space
        put_item(16'h0078, 1'b1, 1'b0);
        put_item(16'h7FFF, 1'b0, 1'b0);
        put_item(CHAR_SPACE, 1'b1, 1'b0);
        put_item(16'h0061, 1'b1, 1'b0);
        put_item(16'h0064, 1'b1, 1'b0);
        put_item(16'h0065, 1'b1, 1'b0);
        put_item(16'h0077, 1'b1, 1'b1);

        // over-long length saturates; key codes above hash never match
        set_pattern('1, 4'd15);
        put_item(16'h0061, 1'b1, 1'b1);
        // hash in the pattern never matches
        set_pattern(48'hB, 4'd1);
        put_item(16'h0023, 1'b1, 1'b1);

        // random part: three back-pressure regimes, several patterns in each
        for (int regime = 0; regime < 3; regime++) begin
            send_idle_pct = (regime == 0) ? 7 : (regime == 1) ? 71 : 0;
            recv_idle_pct = (regime == 0) ? 71 : (regime == 1) ? 7 : 0;
            for (int phase = 0; phase < 9; phase++) begin
                random_pattern();
                if (phase == 2 && regime != 1) begin
                    hold_req <= 1'b1;
                end
                target = items_sent + PHASE_ITEMS;
                while (items_sent < target) send_text();
            end
        end

        settle(8);
        if (errors == 0) begin
            $display("t9_word_prefix_matcher verification clean");
        end else begin
            $display("t9_word_prefix_matcher verification failed");
        end
        $finish;
    end

endmodule

// ===== filelist.f =====
hdl/t9wpm_pkg.sv
hdl/t9wpm_char_key.sv
hdl/t9_word_prefix_matcher.sv
tb/t9wpm_keypad_pkg.sv
tb/t9wpm_match_checker.sv
tb/testbench.sv
